@@ rtl/core/fvcs_pkg.sv @@
`timescale 1ns / 1ps

package fvcs_pkg;

  // Encoder and angle formats
  localparam int unsigned COUNTS_PER_TURN  = 4096;
  localparam int unsigned CNT_W            = $clog2(COUNTS_PER_TURN);
  localparam int unsigned ANG_W            = 16;
  localparam int unsigned ANG_SHIFT        = ANG_W - CNT_W;
  localparam logic [ANG_W-1:0] QUARTER_TURN = ANG_W'(1 << (ANG_W - 2));
  localparam logic [ANG_W-1:0] THIRD_TURN   = ANG_W'(21845);

  // Register and field widths
  localparam int unsigned PP_W             = 6;
  localparam logic [PP_W-1:0] PAIR_CNT_RST = PP_W'(7);
  localparam int unsigned MODE_W           = 2;
  localparam int unsigned VOLT_W           = 15;
  localparam int unsigned SIN_W            = 16;

  // Sine table: quarter wave, one entry per quantized step
  localparam int unsigned SINE_TABLE_DEPTH = 1024;
  localparam int unsigned SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned LUT_IDX_W        = SINE_IDX_W - 2;
  localparam int unsigned LUT_DEPTH        = 1 << LUT_IDX_W;
  localparam int unsigned R_STEP_SHIFT     = (ANG_W - 2) - LUT_IDX_W;
  localparam int unsigned MAG_W            = SIN_W - 1;

  // Voltage and duty formats (voltages in Q25 volts)
  localparam int unsigned U_W              = VOLT_W + SIN_W;
  localparam int unsigned SHIFT_W          = U_W + 2;
  localparam int unsigned X_W              = U_W + 3;
  localparam int unsigned XC_W             = 30;
  localparam logic [XC_W-1:0] SUPPLY_Q25   = XC_W'(12 << 25);
  localparam logic [XC_W-1:0] X_MAX        = XC_W'(24 << 25);
  localparam int unsigned PWM_FULL_SCALE   = 4200;
  localparam int unsigned DUTY_W           = 13;
  // Full range is 24 V = 3 * 2^28 in Q25, so scale by full/3 and drop 28 bits
  localparam int unsigned DUTY_MUL         = PWM_FULL_SCALE / 3;
  localparam int unsigned DUTY_MUL_W       = $clog2(DUTY_MUL + 1);
  localparam int unsigned DUTY_SHIFT       = 28;
  localparam int unsigned DPROD_W          = XC_W + DUTY_MUL_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLOSED  = 2'd0,
    MODE_OPEN    = 2'd1,
    MODE_ALIGN   = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_e;

  // Word leaving the angle stage
  typedef struct packed {
    logic [ANG_W-1:0]         angle;
    logic signed [VOLT_W-1:0] volts;
  } fvcs_ang_t;

  // Word leaving the sine stage
  typedef struct packed {
    logic [2:0][SIN_W-1:0]    sine;
    logic signed [VOLT_W-1:0] volts;
  } fvcs_sin_t;

  typedef logic [LUT_DEPTH-1:0][MAG_W-1:0] sine_lut_t;

  // Odd degree-9 polynomial for sin over the first quadrant, r in 0..16384
  function automatic logic [MAG_W-1:0] sine_q15(logic [14:0] r);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] acc;
    logic [63:0] v;
    t   = 64'(r) << 16;
    t2  = (t * t) >> 30;
    acc = 64'd5026919 - ((64'd172272 * t2) >> 30);
    acc = 64'd85568837 - ((acc * t2) >> 30);
    acc = 64'd693598668 - ((acc * t2) >> 30);
    acc = 64'd1686629713 - ((acc * t2) >> 30);
    v   = (acc * t) >> 30;
    v   = (v + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return MAG_W'(v);
  endfunction

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    for (int k = 0; k < LUT_DEPTH; k++) begin
      lut[k] = sine_q15(15'(k << R_STEP_SHIFT));
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();
  localparam logic [MAG_W-1:0] SINE_PEAK = sine_q15(15'(1 << (ANG_W - 2)));

endpackage

@@ rtl/core/fvcs_angle.sv @@
`timescale 1ns / 1ps

module fvcs_angle (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fvcs_pkg::PP_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [fvcs_pkg::MODE_W-1:0]         mode_i,
  input  logic [fvcs_pkg::CNT_W-1:0]          encoder_count_i,
  input  logic signed [fvcs_pkg::VOLT_W-1:0]  drive_voltage_i,
  input  logic [fvcs_pkg::ANG_W-1:0]          open_angle_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output fvcs_pkg::fvcs_ang_t                 out_word_o
);
  import fvcs_pkg::*;

  logic [PP_W-1:0]        pair_cnt_q;
  logic [CNT_W-1:0]       zero_offset_q;
  logic                   valid_q;
  fvcs_ang_t              word_q;
  fvcs_ang_t              word_d;
  logic [CNT_W+PP_W-1:0]  mech_full;
  logic [CNT_W-1:0]       mech;
  logic [CNT_W-1:0]       elec;
  logic [ANG_W-1:0]       closed_angle;
  logic                   accept;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Mechanical to electrical angle, one turn wraps naturally
  assign mech_full    = encoder_count_i * pair_cnt_q;
  assign mech         = mech_full[CNT_W-1:0];
  assign elec         = mech - zero_offset_q;
  assign closed_angle = {elec, {ANG_SHIFT{1'b0}}} + QUARTER_TURN;

  // Pick angle and voltage per mode; align and release drive zero volts
  always_comb begin
    case (mode_e'(mode_i))
      MODE_CLOSED: begin
        word_d.angle = closed_angle;
        word_d.volts = drive_voltage_i;
      end
      MODE_OPEN: begin
        word_d.angle = open_angle_i;
        word_d.volts = drive_voltage_i;
      end
      default: begin
        word_d.angle = '0;
        word_d.volts = '0;
      end
    endcase
  end

  // Hold the pole pair count and the captured zero offset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_cnt_q    <= PAIR_CNT_RST;
      zero_offset_q <= '0;
    end else begin
      if (cfg_we_i) begin
        pair_cnt_q <= cfg_wdata_i;
      end
      if (accept && (mode_e'(mode_i) == MODE_ALIGN)) begin
        zero_offset_q <= mech;
      end
    end
  end

  // Advance the stage valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

`ifndef SYNTH
  a_offset_only_on_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(zero_offset_q) |-> $past(accept && (mode_e'(mode_i) == MODE_ALIGN)))
    else $error("zero offset moved without an align word");
  a_release_zero_volts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i[1] == 1'b1)) |=> (word_q.volts == '0))
    else $error("release word carries nonzero voltage");
`endif

endmodule

@@ rtl/core/fvcs_sine.sv @@
`timescale 1ns / 1ps

module fvcs_sine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fvcs_pkg::fvcs_ang_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fvcs_pkg::fvcs_sin_t  out_word_o
);
  import fvcs_pkg::*;

  logic                         valid_q;
  fvcs_sin_t                    word_q;
  fvcs_sin_t                    word_d;
  logic [2:0][ANG_W-1:0]        ph_angle;
  logic [2:0][SINE_IDX_W-1:0]   idx;
  logic [2:0][LUT_IDX_W-1:0]    k;
  logic [2:0][MAG_W-1:0]        mag;

  assign in_ready_o = !valid_q || out_ready_i;

  // Phase angles 120 degrees apart
  assign ph_angle[0] = in_word_i.angle;
  assign ph_angle[1] = in_word_i.angle - THIRD_TURN;
  assign ph_angle[2] = in_word_i.angle + THIRD_TURN;

  // Quantize, fold into the first quadrant, look up and apply sign
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      idx[p] = ph_angle[p][ANG_W-1 -: SINE_IDX_W];
      k[p]   = idx[p][LUT_IDX_W-1:0];
      if (idx[p][LUT_IDX_W]) begin
        if (k[p] == '0) begin
          mag[p] = SINE_PEAK;
        end else begin
          mag[p] = SINE_LUT[LUT_IDX_W'(~k[p] + 1'b1)];
        end
      end else begin
        mag[p] = SINE_LUT[k[p]];
      end
      if (idx[p][LUT_IDX_W+1]) begin
        word_d.sine[p] = SIN_W'(0) - SIN_W'(mag[p]);
      end else begin
        word_d.sine[p] = SIN_W'(mag[p]);
      end
    end
    word_d.volts = in_word_i.volts;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

@@ rtl/core/fvcs_mod.sv @@
`timescale 1ns / 1ps

module fvcs_mod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  fvcs_pkg::fvcs_sin_t           in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fvcs_pkg::DUTY_W-1:0]   duty_a_o,
  output logic [fvcs_pkg::DUTY_W-1:0]   duty_b_o,
  output logic [fvcs_pkg::DUTY_W-1:0]   duty_c_o
);
  import fvcs_pkg::*;

  logic                       v_u_q, v_sh_q, v_x_q, v_d_q;
  logic                       rdy_u, rdy_sh, rdy_x, rdy_d;
  logic signed [U_W-1:0]      u_d [3];
  logic signed [U_W-1:0]      u_q [3];
  logic signed [U_W-1:0]      u2_q [3];
  logic signed [U_W-1:0]      hi, lo;
  logic signed [SHIFT_W-1:0]  shift_d, shift_q;
  logic signed [X_W-1:0]      x [3];
  logic [XC_W-1:0]            xc_d [3];
  logic [XC_W-1:0]            xc_q [3];
  logic [DPROD_W-1:0]         dprod [3];
  logic [DUTY_W-1:0]          duty_q [3];

  // Ready chain through the four stages
  assign rdy_d      = !v_d_q || out_ready_i;
  assign rdy_x      = !v_x_q || rdy_d;
  assign rdy_sh     = !v_sh_q || rdy_x;
  assign rdy_u      = !v_u_q || rdy_sh;
  assign in_ready_o = rdy_u;

  // Stage 1: phase voltages, volts times sine
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      u_d[p] = in_word_i.volts * $signed(in_word_i.sine[p]);
    end
  end

  // Stage 2: min/max zero-sequence shift toward half supply
  always_comb begin
    hi = u_q[0];
    lo = u_q[0];
    for (int p = 1; p < 3; p++) begin
      if (u_q[p] > hi) hi = u_q[p];
      if (u_q[p] < lo) lo = u_q[p];
    end
    shift_d = $signed(SHIFT_W'(SUPPLY_Q25)) - SHIFT_W'(hi) - SHIFT_W'(lo);
  end

  // Stage 3: doubled shifted voltage, clamped to the supply range
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      x[p] = (X_W'(u2_q[p]) <<< 1) + X_W'(shift_q);
      if (x[p][X_W-1]) begin
        xc_d[p] = '0;
      end else if (x[p][X_W-2:0] > (X_W-1)'(X_MAX)) begin
        xc_d[p] = X_MAX;
      end else begin
        xc_d[p] = XC_W'(x[p]);
      end
    end
  end

  // Stage 4: scale to compare counts
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      dprod[p] = DPROD_W'(xc_q[p]) * DPROD_W'(DUTY_MUL);
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_u_q  <= 1'b0;
      v_sh_q <= 1'b0;
      v_x_q  <= 1'b0;
      v_d_q  <= 1'b0;
    end else begin
      if (rdy_u)  v_u_q  <= in_valid_i;
      if (rdy_sh) v_sh_q <= v_u_q;
      if (rdy_x)  v_x_q  <= v_sh_q;
      if (rdy_d)  v_d_q  <= v_x_q;
    end
  end

  // Load payload only when a word moves in
  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy_u) begin
      u_q <= u_d;
    end
    if (v_u_q && rdy_sh) begin
      u2_q    <= u_q;
      shift_q <= shift_d;
    end
    if (v_sh_q && rdy_x) begin
      xc_q <= xc_d;
    end
    if (v_x_q && rdy_d) begin
      for (int p = 0; p < 3; p++) begin
        duty_q[p] <= dprod[p][DUTY_SHIFT +: DUTY_W];
      end
    end
  end

  assign out_valid_o = v_d_q;
  assign duty_a_o    = duty_q[0];
  assign duty_b_o    = duty_q[1];
  assign duty_c_o    = duty_q[2];

`ifndef SYNTH
  a_clamp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_x_q |-> ((xc_q[0] <= X_MAX) && (xc_q[1] <= X_MAX) && (xc_q[2] <= X_MAX)))
    else $error("clamped voltage beyond supply range");
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_d_q |-> ((duty_q[0] <= DUTY_W'(PWM_FULL_SCALE))
            && (duty_q[1] <= DUTY_W'(PWM_FULL_SCALE))
            && (duty_q[2] <= DUTY_W'(PWM_FULL_SCALE))))
    else $error("duty beyond full scale");
`endif

endmodule

@@ rtl/core/foc_voltage_commutation_svpwm_top.sv @@
`timescale 1ns / 1ps

// Voltage-mode commutation with min/max space-vector PWM.
// Input channel (in_valid_i / in_stall_o) carries one word: mode, 12-bit
// encoder count, signed q-axis voltage (1/1024 V) and an open-loop angle.
// Output channel (out_valid_o / out_stall_i) returns one word per input:
// three phase compare values in 0..4200.
// Mode 0 drives at the encoder angle less the zero offset plus a quarter
// turn, mode 1 at the given angle, mode 2 captures the zero offset and
// returns half-scale duties, mode 3 returns half-scale duties only.
// The user must write the pole pair count through cfg_we_i / cfg_wdata_i
// only while idle; the block does not enforce it. One word can enter every
// cycle unless the output stalls. Words pass six register stages: angle,
// sine lookup, voltage multiply, min/max shift, clamp, duty scaling.
// A stalled output holds its word; each stage keeps accepting while any
// stage behind it is empty, so in_stall_o rises only when all six are full.
// Reset clears every stage, sets the pole pair count to 7 and the zero
// offset to 0.

module foc_voltage_commutation_svpwm_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fvcs_pkg::PP_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [fvcs_pkg::MODE_W-1:0]         mode_i,
  input  logic [fvcs_pkg::CNT_W-1:0]          encoder_count_i,
  input  logic signed [fvcs_pkg::VOLT_W-1:0]  drive_voltage_i,
  input  logic [fvcs_pkg::ANG_W-1:0]          open_angle_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [fvcs_pkg::DUTY_W-1:0]         duty_a_o,
  output logic [fvcs_pkg::DUTY_W-1:0]         duty_b_o,
  output logic [fvcs_pkg::DUTY_W-1:0]         duty_c_o
);
  import fvcs_pkg::*;

  logic       in_ready;
  logic       ang_valid, ang_ready;
  logic       sin_valid, sin_ready;
  fvcs_ang_t  ang_word;
  fvcs_sin_t  sin_word;

  assign in_stall_o = !in_ready;

  fvcs_angle u_angle (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready),
    .mode_i          (mode_i),
    .encoder_count_i (encoder_count_i),
    .drive_voltage_i (drive_voltage_i),
    .open_angle_i    (open_angle_i),
    .out_valid_o     (ang_valid),
    .out_ready_i     (ang_ready),
    .out_word_o      (ang_word)
  );

  fvcs_sine u_sine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ang_valid),
    .in_ready_o  (ang_ready),
    .in_word_i   (ang_word),
    .out_valid_o (sin_valid),
    .out_ready_i (sin_ready),
    .out_word_o  (sin_word)
  );

  fvcs_mod u_mod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sin_valid),
    .in_ready_o  (sin_ready),
    .in_word_i   (sin_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .duty_a_o    (duty_a_o),
    .duty_b_o    (duty_b_o),
    .duty_c_o    (duty_c_o)
  );

`ifndef SYNTH
  a_empty_output_never_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty output stage");
  a_stall_needs_full_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (ang_valid && sin_valid && out_valid_o && out_stall_i))
    else $error("input stalled while a stage is free");
`endif

endmodule
